### sv/acsr_pkg.sv
// Shared types and constants for the ambient contrast strength ramp.
`timescale 1ns / 1ps

package acsr_pkg;

    // Field widths fixed by the item format
    localparam int LUX_W = 17;
    localparam int AMB_W = 16;
    localparam int STR_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MAP_INDEX_W = 3;
    localparam int DIV_STEPS = STR_W;

    // Item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_LUX  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_UP_STEP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [2:0]       entry_index;
        logic [LUX_W-1:0] entry_lux;
        logic [AMB_W-1:0] entry_ambient;
        logic [STR_W-1:0] entry_strength;
        logic [LUX_W-1:0] lux;
    } in_item_t;

    typedef struct packed {
        logic [AMB_W-1:0]       amb_code;
        logic [STR_W-1:0]       strength;
        logic [STR_W-1:0]       target;
        logic [STR_W-1:0]       steps_left;
        logic [MAP_INDEX_W-1:0] map_index;
        logic                   refresh;
    } out_item_t;

    // One lux map entry as held in the map RAM
    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic [AMB_W-1:0] ambient;
        logic [STR_W-1:0] strength;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic write_entry;
        logic tick_step;
        logic scan_rd;
        logic scan_cmp;
        logic sel_rd;
        logic sel_chk;
        logic div_run;
        logic div_end;
        logic ramp_step;
        logic fin_rd;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       scan_more;
        logic       need_div;
        logic       div_last;
        logic       out_free;
    } status_t;

endpackage

### sv/acsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module acsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/acsr_ctrl.sv
// Sequencing state machine for the ambient contrast strength ramp.
`timescale 1ns / 1ps

module acsr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  acsr_pkg::status_t status,
    output acsr_pkg::cmd_t   cmd
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_WRITE    = 12'b0000_0000_0010,
        ST_TICK     = 12'b0000_0000_0100,
        ST_SCAN_RD  = 12'b0000_0000_1000,
        ST_SCAN_CMP = 12'b0000_0001_0000,
        ST_SEL_RD   = 12'b0000_0010_0000,
        ST_SEL_CHK  = 12'b0000_0100_0000,
        ST_DIV      = 12'b0000_1000_0000,
        ST_CNT      = 12'b0001_0000_0000,
        ST_STEP     = 12'b0010_0000_0000,
        ST_RD       = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (status.mode)
                        acsr_pkg::MODE_LOAD: state_next = ST_WRITE;
                        acsr_pkg::MODE_LUX:  state_next = ST_SCAN_RD;
                        acsr_pkg::MODE_TICK: state_next = ST_TICK;
                        default:             state_next = ST_RD;
                    endcase
                end
            end
            ST_WRITE:    state_next = ST_RD;
            ST_TICK:     state_next = ST_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: state_next = status.scan_more ? ST_SCAN_RD : ST_SEL_RD;
            ST_SEL_RD:   state_next = ST_SEL_CHK;
            ST_SEL_CHK:  state_next = status.need_div ? ST_DIV : ST_STEP;
            ST_DIV:      state_next = status.div_last ? ST_CNT : ST_DIV;
            ST_CNT:      state_next = ST_STEP;
            ST_STEP:     state_next = ST_RD;
            ST_RD:       state_next = ST_DONE;
            ST_DONE:     state_next = status.out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode
    always_comb begin
        cmd             = '0;
        cmd.capture     = s_valid && s_ready;
        cmd.write_entry = (state_reg == ST_WRITE);
        cmd.tick_step   = (state_reg == ST_TICK);
        cmd.scan_rd     = (state_reg == ST_SCAN_RD);
        cmd.scan_cmp    = (state_reg == ST_SCAN_CMP);
        cmd.sel_rd      = (state_reg == ST_SEL_RD);
        cmd.sel_chk     = (state_reg == ST_SEL_CHK);
        cmd.div_run     = (state_reg == ST_DIV);
        cmd.div_end     = (state_reg == ST_CNT);
        cmd.ramp_step   = (state_reg == ST_STEP);
        cmd.fin_rd      = (state_reg == ST_RD);
        cmd.out_load    = (state_reg == ST_DONE) && status.out_free;
    end

endmodule

### sv/acsr_dpath.sv
// Datapath: map RAM, lux scan, step-count divider, ramp and result register.
`timescale 1ns / 1ps

module acsr_dpath #(
    parameter int MAP_ENTRIES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  acsr_pkg::in_item_t                   s_item,
    input  logic                                 cfg_valid,
    input  logic [acsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [acsr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  acsr_pkg::cmd_t                       cmd,
    output acsr_pkg::status_t                    status,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output acsr_pkg::out_item_t                  m_item
);

    localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int SW = acsr_pkg::STR_W;

    // Ramp move: rise by up, fall by down, or snap onto the target
    function automatic logic [SW-1:0] ramp_next(input logic [SW-1:0] s,
                                                input logic [SW-1:0] t,
                                                input logic [SW-1:0] up,
                                                input logic [SW-1:0] dn);
        logic [SW:0] up_sum;
        logic [SW:0] dn_sum;
        up_sum = {1'b0, s} + {1'b0, up};
        dn_sum = {1'b0, t} + {1'b0, dn};
        if (up_sum < {1'b0, t}) begin
            ramp_next = up_sum[SW-1:0];
        end else if ({1'b0, s} > dn_sum) begin
            ramp_next = s - dn;
        end else begin
            ramp_next = t;
        end
    endfunction

    acsr_pkg::in_item_t  item_reg,   item_next;
    logic [SW-1:0]       up_reg,     up_next;
    logic [SW-1:0]       down_reg,   down_next;
    logic [3:0]          mcount_reg, mcount_next;
    logic [SW-1:0]       cur_reg,    cur_next;
    logic [SW-1:0]       tgt_reg,    tgt_next;
    logic [SW-1:0]       cnt_reg,    cnt_next;
    logic [IDX_W-1:0]    sel_reg,    sel_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;
    logic [LIM_W-1:0]    scan_reg,   scan_next;
    logic [SW-1:0]       divisor_reg, divisor_next;
    logic [SW-1:0]       rem_reg,    rem_next;
    logic [SW-1:0]       quo_reg,    quo_next;
    logic [2:0]          div_cnt_reg, div_cnt_next;
    logic                refresh_reg, refresh_next;
    logic                m_valid_reg, m_valid_next;
    acsr_pkg::out_item_t m_item_reg, m_item_next;

    acsr_pkg::entry_t    wr_entry;
    acsr_pkg::entry_t    rd_entry;
    logic [$bits(acsr_pkg::entry_t)-1:0] rd_data;
    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;

    logic [LIM_W-1:0]    scan_lim;
    logic [LIM_W-1:0]    scan_plus;
    logic                lux_below;
    logic [SW:0]         div_sh;
    logic [SW:0]         div_sub;
    logic                div_fit;
    logic                rising;
    logic [SW-1:0]       diff;
    logic [SW-1:0]       step_sz;

    // Map RAM: one entry per map slot
    assign wr_entry.lux      = item_reg.entry_lux;
    assign wr_entry.ambient  = item_reg.entry_ambient;
    assign wr_entry.strength = item_reg.entry_strength;
    assign ram_we    = cmd.write_entry && (int'(item_reg.entry_index) < MAP_ENTRIES);
    assign ram_re    = cmd.scan_rd || cmd.sel_rd || cmd.fin_rd;
    assign ram_raddr = cmd.scan_rd ? scan_reg[IDX_W-1:0] :
                       cmd.sel_rd  ? idx_reg : sel_reg;
    assign rd_entry  = acsr_pkg::entry_t'(rd_data);

    acsr_ram #(
        .WIDTH ($bits(acsr_pkg::entry_t)),
        .DEPTH (MAP_ENTRIES)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (IDX_W'(item_reg.entry_index)),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Number of entries scanned: zero counts as one, clamp to map size
    always_comb begin
        if (mcount_reg == 4'd0) begin
            scan_lim = LIM_W'(1);
        end else if (LIM_W'(mcount_reg) > LIM_W'(MAP_ENTRIES)) begin
            scan_lim = LIM_W'(MAP_ENTRIES);
        end else begin
            scan_lim = LIM_W'(mcount_reg);
        end
    end

    assign scan_plus = scan_reg + LIM_W'(1);
    assign lux_below = item_reg.lux < rd_entry.lux;

    // One restoring division step per cycle
    assign div_sh  = {rem_reg, quo_reg[SW-1]};
    assign div_fit = div_sh >= {1'b0, divisor_reg};
    assign div_sub = div_sh - {1'b0, divisor_reg};

    // Distance and step size toward a new target
    assign rising  = rd_entry.strength > cur_reg;
    assign diff    = rising ? (rd_entry.strength - cur_reg) : (cur_reg - rd_entry.strength);
    assign step_sz = rising ? up_reg : down_reg;

    // Status to controller
    assign status.mode      = s_item.mode;
    assign status.scan_more = !lux_below && (scan_plus < scan_lim);
    assign status.need_div  = (tgt_reg != rd_entry.strength);
    assign status.div_last  = (div_cnt_reg == 3'(acsr_pkg::DIV_STEPS - 1));
    assign status.out_free  = !m_valid_reg || m_ready;

    // Next-state logic
    always_comb begin
        item_next    = item_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        mcount_next  = mcount_reg;
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        scan_next    = scan_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        refresh_next = refresh_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;

        // configuration writes
        if (cfg_valid) begin
            unique case (cfg_index)
                acsr_pkg::CFG_UP_STEP:   up_next = cfg_data;
                acsr_pkg::CFG_DOWN_STEP: down_next = cfg_data;
                acsr_pkg::CFG_MAP_COUNT: mcount_next = cfg_data[3:0];
                default: ;
            endcase
        end

        if (cmd.capture) begin
            item_next    = s_item;
            scan_next    = '0;
            idx_next     = '0;
            refresh_next = 1'b0;
        end

        // frame tick: one step while steps remain
        if (cmd.tick_step && (cnt_reg != '0)) begin
            cur_next     = ramp_next(cur_reg, tgt_reg, up_reg, down_reg);
            cnt_next     = cnt_reg - SW'(1);
            refresh_next = 1'b1;
        end

        // scan: keep the last entry at or below the lux before the first above it
        if (cmd.scan_cmp) begin
            if (!lux_below) begin
                idx_next = scan_reg[IDX_W-1:0];
            end
            scan_next = scan_plus;
        end

        // new target: start the step-count division
        if (cmd.sel_chk && status.need_div) begin
            tgt_next     = rd_entry.strength;
            divisor_next = (step_sz == '0) ? SW'(1) : step_sz;
            rem_next     = '0;
            quo_next     = diff;
            div_cnt_next = '0;
        end

        if (cmd.div_run) begin
            rem_next     = div_fit ? div_sub[SW-1:0] : div_sh[SW-1:0];
            quo_next     = {quo_reg[SW-2:0], div_fit};
            div_cnt_next = div_cnt_reg + 3'd1;
        end

        // ceiling of the quotient
        if (cmd.div_end) begin
            cnt_next = quo_reg + SW'(rem_reg != '0);
        end

        // lux sample: one ramp step while steps remain, and record the selected entry
        if (cmd.ramp_step) begin
            if (cnt_reg != '0) begin
                cur_next = ramp_next(cur_reg, tgt_reg, up_reg, down_reg);
                cnt_next = cnt_reg - SW'(1);
            end
            if (sel_reg != idx_reg) begin
                sel_next     = idx_reg;
                refresh_next = 1'b1;
            end
        end

        // result register
        if (cmd.out_load) begin
            m_valid_next           = 1'b1;
            m_item_next.amb_code   = rd_entry.ambient;
            m_item_next.strength   = cur_reg;
            m_item_next.target     = tgt_reg;
            m_item_next.steps_left = cnt_reg;
            m_item_next.map_index  = acsr_pkg::MAP_INDEX_W'(sel_reg);
            m_item_next.refresh    = refresh_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg      <= SW'(1);
            down_reg    <= SW'(1);
            mcount_reg  <= 4'd1;
            cur_reg     <= '0;
            tgt_reg     <= '0;
            cnt_reg     <= '0;
            sel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            up_reg      <= up_next;
            down_reg    <= down_next;
            mcount_reg  <= mcount_next;
            cur_reg     <= cur_next;
            tgt_reg     <= tgt_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        refresh_reg <= refresh_next;
        m_item_reg  <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### sv/ambient_contrast_strength_ramp.sv
// Top level of the ambient contrast strength ramp.
`timescale 1ns / 1ps
//
// Items enter on s_valid/s_ready (s_item) and one result per item leaves on
// m_valid/m_ready (m_item). Registers are written on cfg_valid/cfg_ready
// (cfg_index, cfg_data); cfg_ready is always high.
// One item is worked on at a time; s_ready is high only while the sequencer
// is idle. A lux sample scans the map entries in use, one RAM read and
// compare each, then reads the selected entry; on a target change the new
// step count comes from a shift-subtract divider before the ramp step.
// A new item is taken the cycle after its result is loaded into the output
// register, so the input side keeps going while that result waits.
// When m_ready stays low the finished result sits in the output register;
// the following item is accepted and processed but parks before its result
// until the register empties.
// Reset (aresetn low, synchronous) clears the strength, target, step count,
// selected entry and output valid, and sets up_step, down_step and
// map_count to 1. Map entries hold no reset value and must be loaded first.

module ambient_contrast_strength_ramp #(
    parameter int MAP_ENTRIES = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  acsr_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output acsr_pkg::out_item_t              m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [acsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [acsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    acsr_pkg::cmd_t    cmd;
    acsr_pkg::status_t status;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    acsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    acsr_dpath #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

### sv/acsr_checker.sv
// Port-level checks for the ambient contrast strength ramp, bound to the top.
`timescale 1ns / 1ps

module acsr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input acsr_pkg::out_item_t m_item
);

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // One item at a time: no acceptance in the cycle after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after an accepted item");

    // A result is never raised by the edge that accepts an item
    a_no_same_cycle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after acceptance");

endmodule

bind ambient_contrast_strength_ramp acsr_checker u_acsr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

### test/tb_ambient_contrast_strength_ramp.sv
// Self-checking testbench for the ambient contrast strength ramp: directed and random items.
`timescale 1ns / 1ps

module tb_ambient_contrast_strength_ramp;

    localparam int MAP_N = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LUX_MAX = (1 << acsr_pkg::LUX_W) - 1;
    localparam int IDLE_PCT = 35;
    // index with no register behind it; writes must change nothing
    localparam logic [acsr_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    acsr_pkg::in_item_t                   s_item = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    acsr_pkg::out_item_t                  m_item;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [acsr_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [acsr_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    always #1 aclk = ~aclk;

    ambient_contrast_strength_ramp #(
        .MAP_ENTRIES(MAP_N)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted block state: lux map, ramp and register copies
    logic [acsr_pkg::LUX_W-1:0] thr_mem [MAP_N];
    logic [acsr_pkg::AMB_W-1:0] amb_mem [MAP_N];
    logic [acsr_pkg::STR_W-1:0] str_mem [MAP_N];
    int unsigned cur_str = 0;
    int unsigned tgt_str = 0;
    int unsigned ramp_left = 0;
    int unsigned sel_idx = 0;
    int unsigned up_reg = 1;
    int unsigned down_reg = 1;
    int unsigned count_reg = 1;

    acsr_pkg::in_item_t  items_to_send [$];
    acsr_pkg::out_item_t results_due [$];
    logic [acsr_pkg::LUX_W-1:0] plan_thr [MAP_N];   // thresholds as queued, for picking lux

    bit calm = 1'b0;                      // no idling on either side while set
    int errors = 0;
    int n_queued = 0;
    int n_done = 0;
    int n_load = 0;
    int n_lux = 0;
    int n_tick = 0;
    int n_spare = 0;
    int n_cfg = 0;
    int n_refresh = 0;
    int quiet = 0;

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("ERROR result %0d: %s", n_done, msg);
    endtask

    // One ramp step toward the target, snapping when within one step
    task automatic ramp_one();
        if (cur_str + up_reg < tgt_str) begin
            cur_str = cur_str + up_reg;
        end else if (cur_str > tgt_str + down_reg) begin
            cur_str = cur_str - down_reg;
        end else begin
            cur_str = tgt_str;
        end
        if (ramp_left > 0) begin
            ramp_left--;
        end
    endtask

    // Apply one accepted item to the predicted state and form its result
    task automatic advance_ramp(input acsr_pkg::in_item_t it,
                                output acsr_pkg::out_item_t res);
        int unsigned n;
        int unsigned pick;
        int unsigned goal;
        int unsigned stride;
        int unsigned gap;
        logic        flag;
        flag = 1'b0;
        case (it.mode)
            acsr_pkg::MODE_LOAD: begin
                n_load++;
                thr_mem[it.entry_index] = it.entry_lux;
                amb_mem[it.entry_index] = it.entry_ambient;
                str_mem[it.entry_index] = it.entry_strength;
            end
            acsr_pkg::MODE_LUX: begin
                n_lux++;
                // zero count means one entry, large counts saturate
                n = (count_reg == 0) ? 1 : ((count_reg > MAP_N) ? MAP_N : count_reg);
                pick = 0;
                for (int i = 0; i < n; i++) begin
                    if (it.lux < thr_mem[i]) begin
                        break;
                    end
                    pick = i;
                end
                goal = 32'(str_mem[pick]);
                if (tgt_str != goal) begin
                    stride = (goal > cur_str) ? up_reg : down_reg;
                    gap = (goal > cur_str) ? goal - cur_str : cur_str - goal;
                    if (stride == 0) begin
                        stride = 1;
                    end
                    tgt_str = goal;
                    ramp_left = ((gap + stride - 1) / stride) & 32'hFF;
                end
                if (ramp_left != 0) begin
                    ramp_one();
                end
                if (sel_idx != pick) begin
                    sel_idx = pick;
                    flag = 1'b1;
                end
            end
            acsr_pkg::MODE_TICK: begin
                n_tick++;
                if (ramp_left > 0) begin
                    ramp_one();
                    flag = 1'b1;
                end
            end
            default: begin
                n_spare++;
            end
        endcase
        res.amb_code = amb_mem[sel_idx];
        res.strength = acsr_pkg::STR_W'(cur_str);
        res.target = acsr_pkg::STR_W'(tgt_str);
        res.steps_left = acsr_pkg::STR_W'(ramp_left);
        res.map_index = acsr_pkg::MAP_INDEX_W'(sel_idx);
        res.refresh = flag;
    endtask

    // Item driver: presents queued items, idling at random between them
    always @(posedge aclk) begin : drive_items
        acsr_pkg::out_item_t due;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_ramp(s_item, due);
                results_due.push_back(due);
            end
            if (!s_valid || s_ready) begin
                if (items_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s_item <= items_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random backpressure, field-by-field compare
    always @(posedge aclk) begin : watch_results
        acsr_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("result with no item outstanding");
                end else begin
                    want = results_due.pop_front();
                    n_done++;
                    if (m_item.refresh) begin
                        n_refresh++;
                    end
                    if (m_item.amb_code !== want.amb_code) begin
                        flag_mismatch($sformatf("amb_code %h, expected %h",
                                                m_item.amb_code, want.amb_code));
                    end
                    if (m_item.strength !== want.strength) begin
                        flag_mismatch($sformatf("strength %0d, expected %0d",
                                                m_item.strength, want.strength));
                    end
                    if (m_item.target !== want.target) begin
                        flag_mismatch($sformatf("target %0d, expected %0d",
                                                m_item.target, want.target));
                    end
                    if (m_item.steps_left !== want.steps_left) begin
                        flag_mismatch($sformatf("steps_left %0d, expected %0d",
                                                m_item.steps_left, want.steps_left));
                    end
                    if (m_item.map_index !== want.map_index) begin
                        flag_mismatch($sformatf("map_index %0d, expected %0d",
                                                m_item.map_index, want.map_index));
                    end
                    if (m_item.refresh !== want.refresh) begin
                        flag_mismatch($sformatf("refresh %b, expected %b",
                                                m_item.refresh, want.refresh));
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAIL ambient_contrast_strength_ramp");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Random filler for every field, so unused fields toggle too
    function automatic acsr_pkg::in_item_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return acsr_pkg::in_item_t'(raw[$bits(acsr_pkg::in_item_t)-1:0]);
    endfunction

    task automatic put_item(input acsr_pkg::in_item_t it);
        items_to_send.push_back(it);
        n_queued++;
    endtask

    task automatic put_load(input int idx, input int lux, input int amb, input int str);
        acsr_pkg::in_item_t it;
        it = noise_item();
        it.mode = acsr_pkg::MODE_LOAD;
        it.entry_index = 3'(idx);
        it.entry_lux = acsr_pkg::LUX_W'(lux);
        it.entry_ambient = acsr_pkg::AMB_W'(amb);
        it.entry_strength = acsr_pkg::STR_W'(str);
        plan_thr[idx] = acsr_pkg::LUX_W'(lux);
        put_item(it);
    endtask

    task automatic put_lux(input int lux);
        acsr_pkg::in_item_t it;
        it = noise_item();
        it.mode = acsr_pkg::MODE_LUX;
        it.lux = acsr_pkg::LUX_W'(lux);
        put_item(it);
    endtask

    task automatic put_tick();
        acsr_pkg::in_item_t it;
        it = noise_item();
        it.mode = acsr_pkg::MODE_TICK;
        put_item(it);
    endtask

    // Lux value: mostly on or next to a threshold, sometimes anywhere or at an end
    function automatic int pick_lux();
        int v;
        int r;
        r = int'($urandom_range(9));
        if (r < 3) begin
            v = int'($urandom_range(LUX_MAX));
        end else if (r == 3) begin
            v = $urandom_range(1) ? 0 : LUX_MAX;
        end else begin
            v = int'(plan_thr[$urandom_range(MAP_N - 1)]);
            v = v + int'($urandom_range(2)) - 1;
            if (v < 0) begin
                v = 0;
            end
            if (v > LUX_MAX) begin
                v = LUX_MAX;
            end
        end
        return v;
    endfunction

    task automatic put_random();
        int roll;
        int k;
        int v;
        acsr_pkg::in_item_t it;
        roll = int'($urandom_range(99));
        it = noise_item();
        if (roll < 40) begin
            put_lux(pick_lux());
        end else if (roll < 80) begin
            put_tick();
        end else if (roll < 96) begin
            // reload one entry, half the time near its old threshold to keep the map roughly ordered
            k = int'(it.entry_index);
            if (roll < 88) begin
                v = int'(plan_thr[k]) + int'($urandom_range(400)) - 200;
                v = (v < 0) ? 0 : ((v > LUX_MAX) ? LUX_MAX : v);
            end else begin
                v = int'(it.entry_lux);
            end
            put_load(k, v, int'(it.entry_ambient), int'(it.entry_strength));
        end else begin
            it.mode = acsr_pkg::MODE_NONE;
            put_item(it);
        end
    endtask

    // Block until every queued item has produced its result, then let the block drain
    task automatic settle();
        while (n_done < n_queued) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [acsr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            acsr_pkg::CFG_UP_STEP: begin
                up_reg = 32'(val);
            end
            acsr_pkg::CFG_DOWN_STEP: begin
                down_reg = 32'(val);
            end
            acsr_pkg::CFG_MAP_COUNT: begin
                count_reg = 32'(val[3:0]);
            end
            default: ;
        endcase
    endtask

    // New register setting, fresh map, then random traffic
    task automatic run_phase(input logic [7:0] up, input logic [7:0] down,
                             input logic [7:0] count, input int n);
        int base;
        bit shuffled;
        settle();
        write_reg(acsr_pkg::CFG_UP_STEP, up);
        write_reg(acsr_pkg::CFG_DOWN_STEP, down);
        write_reg(acsr_pkg::CFG_MAP_COUNT, count);
        shuffled = ($urandom_range(4) == 0);
        base = int'($urandom_range(3000));
        for (int i = 0; i < MAP_N; i++) begin
            put_load(i, shuffled ? int'($urandom_range(LUX_MAX)) : base,
                     int'($urandom_range(16'hFFFF)), int'($urandom_range(255)));
            base = base + int'($urandom_range(16000));
        end
        repeat (n - MAP_N) put_random();
    endtask

    initial begin
        acsr_pkg::in_item_t odd;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Whole map loaded first, field extremes at both ends
        put_load(0, 0, 16'h0000, 0);
        put_load(1, 100, 16'h1234, 200);
        put_load(2, 1000, 16'h8001, 10);
        put_load(3, 5000, 16'h00FF, 255);
        put_load(4, 20000, 16'hAAAA, 128);
        put_load(5, 50000, 16'h5555, 0);
        put_load(6, 100000, 16'h7FFF, 77);
        put_load(7, LUX_MAX, 16'hFFFF, 255);
        put_lux(LUX_MAX);      // one entry in use: always entry 0
        put_tick();            // settled, no step
        odd = '1;
        odd.mode = acsr_pkg::MODE_NONE;
        put_item(odd);

        // Full map, unit steps: start a long ramp up, then back down to settled
        settle();
        write_reg(acsr_pkg::CFG_MAP_COUNT, 8'd8);
        put_lux(LUX_MAX);
        put_tick();
        put_tick();
        put_lux(0);
        put_tick();
        put_tick();
        put_tick();
        put_lux(99);           // just below entry 1
        put_lux(100);          // exactly on entry 1

        // Largest steps: every move snaps straight to the target
        settle();
        write_reg(acsr_pkg::CFG_UP_STEP, 8'd255);
        write_reg(acsr_pkg::CFG_DOWN_STEP, 8'd255);
        put_lux(5000);
        put_lux(50000);
        put_lux(4999);

        // Random phases across register settings
        run_phase(8'd0, 8'd0, 8'd0, 250);        // zero steps, zero count
        run_phase(8'd255, 8'd255, 8'd15, 250);   // count above map size
        settle();
        write_reg(CFG_SPARE, 8'hA5);
        run_phase(8'd1, 8'd255, 8'd8, 250);
        run_phase(8'd255, 8'd1, 8'hF3, 250);     // bits above the count field
        run_phase(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                  8'($urandom_range(1, 8)), 250);
        settle();
        calm = 1'b1;
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(15)), 250);
        settle();
        calm = 1'b0;
        run_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), 8'd8, 250);
        settle();

        $display("Ran %0d map loads, %0d lux samples, %0d frame ticks, %0d unused-mode items",
                 n_load, n_lux, n_tick, n_spare);
        $display("across %0d register writes; %0d results checked, %0d with refresh set",
                 n_cfg, n_done, n_refresh);
        if (errors == 0) begin
            $display("PASS ambient_contrast_strength_ramp");
        end else begin
            $display("FAIL ambient_contrast_strength_ramp");
        end
        $finish;
    end

endmodule
